[rtl/core/dc_blocked_sample_block_buffer_defines.svh]
// ----------------------------------------------------------------------------
// dc blocked sample block buffer - assertion macros
// shared concurrent assertion forms for the block's rtl files
// ----------------------------------------------------------------------------
`ifndef DC_BLOCKED_SAMPLE_BLOCK_BUFFER_DEFINES_SVH
`define DC_BLOCKED_SAMPLE_BLOCK_BUFFER_DEFINES_SVH

// property checked on every clock edge out of reset
`define DCBB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define DCBB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/dcbb_pkg.sv]
// ----------------------------------------------------------------------------
// dcbb_pkg
// types, constants and helpers shared by the dc blocked sample buffer
// ----------------------------------------------------------------------------
`default_nettype none

package dcbb_pkg;

  // fixed field widths
  localparam int unsigned IDX_W   = 6;   // ring index
  localparam int unsigned CNT_W   = 7;   // fill and frame counts
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned Y_W     = 24;
  localparam int unsigned MAX_RUN = 64;  // frames per input item at most

  localparam logic [COEF_W-1:0] COEF_RESET = 16'd65208;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUM,
    F_DRAIN
  } front_state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [SMP_W-1:0] sample;
    logic                    sink_ready;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] frames;
  } drain_cmd_t;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        addr;
    logic signed [SMP_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic rd_done;
    logic busy;
  } back_status_t;

  // ring index add, operands below twice the depth
  function automatic logic [IDX_W-1:0] idx_add(logic [IDX_W-1:0] a, logic [IDX_W:0] b,
                                                logic [IDX_W:0] depth);
    logic [IDX_W+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= {1'b0, depth}) begin
      s = s - {1'b0, depth};
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/dc_blocked_sample_block_buffer.sv]
// ----------------------------------------------------------------------------
// dc_blocked_sample_block_buffer
// dc blocking filter into a ring store, drained in blocks as stereo frames
// ----------------------------------------------------------------------------
// usage:
//   in channel (valid/ready) takes an item: push a Q1.15 sample, or clear the
//   ring and filter history. a push with sink_ready set drains every complete
//   block, up to 64 frames, on the out channel (valid/ready), oldest first,
//   left equal to right, last_of_run on the final frame of the run.
//   cfg_we_i writes the pole coefficient (Q0.16); write only while idle.
// timing:
//   a push passes the front's sum state and, with sink_ready, a drain state
//   that queues a command for any whole blocks. the first frame shows after
//   the queue entry, the back's active flag and output register, then one
//   frame per cycle while the sink takes them. the front runs ahead of the
//   drain through a two entry command queue; a push waits while the front is
//   busy, the queue is full or undrained frames hold the slot it needs.
// reset: pointers, counts and filter history clear, coefficient goes to
//   65208; store contents stay undefined, no clearing pass is needed.
// stall: a stalled sink holds the output register; drained frames wait in
//   the store and new pushes continue until the ring runs out of free slots.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_blocked_sample_block_buffer
  import dcbb_pkg::*;
#(
  parameter int unsigned BLOCK_FRAMES = 16,
  parameter int unsigned STORE_DEPTH  = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [COEF_W-1:0] cfg_wdata_i
);

  logic         fifo_full;
  logic         cmd_push;
  drain_cmd_t   cmd_in;
  logic         cmd_valid;
  drain_cmd_t   cmd_out;
  logic         cmd_pop;
  store_wr_t    store_wr;
  back_status_t back_status;

  // filter, store write and drain planning
  dcbb_front #(
    .BLOCK_FRAMES(BLOCK_FRAMES),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fifo_full_i(fifo_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .wr_o       (store_wr),
    .status_i   (back_status)
  );

  // drain command queue
  dcbb_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (fifo_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .data_o (cmd_out)
  );

  // store and frame output
  dcbb_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .wr_i       (store_wr),
    .status_o   (back_status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/core/dcbb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// dcbb_cmd_fifo
// two entry queue of drain commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dcbb_cmd_fifo
  import dcbb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  drain_cmd_t      data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output drain_cmd_t      data_o
);

  drain_cmd_t entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  // pointer and count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = entry_q[rptr_q];

endmodule

`default_nettype wire

[rtl/core/dcbb_front.sv]
// ----------------------------------------------------------------------------
// dcbb_front
// accepts items, runs the dc blocker, writes the store and plans drains
// ----------------------------------------------------------------------------
`default_nettype none
`include "dc_blocked_sample_block_buffer_defines.svh"

module dcbb_front
  import dcbb_pkg::*;
#(
  parameter int unsigned BLOCK_FRAMES = 16,
  parameter int unsigned STORE_DEPTH  = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  input  wire logic              cfg_we_i,
  input  wire logic [COEF_W-1:0] cfg_wdata_i,
  input  wire logic              fifo_full_i,
  output logic                   cmd_push_o,
  output drain_cmd_t             cmd_o,
  output store_wr_t              wr_o,
  input  back_status_t           status_i
);

  localparam int unsigned PROD_W = Y_W + COEF_W + 1;
  localparam int unsigned SUM_W  = Y_W + 2;
  localparam logic [CNT_W:0] DEPTH_C = (CNT_W+1)'(STORE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_I = (IDX_W+1)'(STORE_DEPTH);
  localparam logic [IDX_W:0] STEP_I  = (IDX_W+1)'(BLOCK_FRAMES % STORE_DEPTH);
  localparam logic [IDX_W:0] ONE_I   = (IDX_W+1)'(1);
  localparam logic [CNT_W:0] BLK_C   = (CNT_W+1)'(BLOCK_FRAMES);
  localparam logic [CNT_W:0] RUN_C   = (CNT_W+1)'(MAX_RUN);
  localparam logic signed [SUM_W-1:0] Y_HI = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] Y_LO = -SUM_W'(8388608);
  localparam logic signed [Y_W-1:0]   S_HI = Y_W'(32767);
  localparam logic signed [Y_W-1:0]   S_LO = -Y_W'(32767);

  front_state_e              state_q, state_d;
  logic [COEF_W-1:0]         coef_q;
  logic signed [SMP_W-1:0]   x_q, x_d;
  logic                      sink_ready_q, sink_ready_d;
  logic signed [SMP_W-1:0]   px_q, px_d;
  logic signed [Y_W-1:0]     py_q, py_d;
  logic signed [Y_W:0]       prod_q, prod_d;
  logic [CNT_W-1:0]          fill_q, fill_d;
  logic [CNT_W-1:0]          outst_q, outst_d;
  logic [IDX_W-1:0]          rd_q, rd_d;
  logic [IDX_W-1:0]          wr_q, wr_d;
  logic [IDX_W-1:0]          start_q, start_d;
  logic [CNT_W-1:0]          run_q, run_d;

  logic signed [PROD_W-1:0]  prod_full;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [Y_W-1:0]     y_sat;
  logic signed [SMP_W-1:0]   smp_out;
  logic                      room_ok;
  logic                      accept;
  logic                      more_blk;

  // pole product, floor shift by the coefficient width
  assign prod_full = py_q * $signed({1'b0, coef_q});

  // filter sum, saturation to the history width and output clamp
  always_comb begin
    y_sum = SUM_W'(x_q) - SUM_W'(px_q) + SUM_W'(prod_q);
    if (y_sum > Y_HI) begin
      y_sat = Y_HI[Y_W-1:0];
    end else if (y_sum < Y_LO) begin
      y_sat = Y_LO[Y_W-1:0];
    end else begin
      y_sat = y_sum[Y_W-1:0];
    end
    if (y_sat > S_HI) begin
      smp_out = S_HI[SMP_W-1:0];
    end else if (y_sat < S_LO) begin
      smp_out = S_LO[SMP_W-1:0];
    end else begin
      smp_out = y_sat[SMP_W-1:0];
    end
  end

  // a push may not land on a slot the back still has to read
  assign room_ok = (outst_q == '0) || (({1'b0, fill_q} + {1'b0, outst_q}) < DEPTH_C);
  assign in_ready_o = (state_q == F_IDLE) && !fifo_full_i && room_ok;
  assign accept     = in_valid_i && in_ready_o;
  assign more_blk   = ({1'b0, fill_q} >= BLK_C) && (({1'b0, run_q} + BLK_C) <= RUN_C);

  // sequencer: accept, clear or filter and store, then count whole blocks
  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    sink_ready_d = sink_ready_q;
    px_d         = px_q;
    py_d         = py_q;
    prod_d       = prod_q;
    fill_d       = fill_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    start_d      = start_q;
    run_d        = run_q;
    cmd_push_o   = 1'b0;
    wr_o         = '{en: 1'b0, addr: wr_q, data: smp_out};
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_data_i.op == OP_CLEAR) begin
            // restart writes at the read point so frames still being
            // drained stay behind it, drop the filter history
            fill_d = '0;
            wr_d   = rd_q;
            px_d   = '0;
            py_d   = '0;
          end else begin
            x_d          = in_data_i.sample;
            sink_ready_d = in_data_i.sink_ready;
            prod_d       = prod_full[PROD_W-1:COEF_W];
            state_d      = F_SUM;
          end
        end
      end
      F_SUM: begin
        wr_o.en = 1'b1;
        px_d    = x_q;
        py_d    = y_sat;
        wr_d    = idx_add(wr_q, ONE_I, DEPTH_I);
        if ({1'b0, fill_q} < DEPTH_C) begin
          fill_d = fill_q + CNT_W'(1);
        end else begin
          // full ring drops its oldest item
          rd_d = idx_add(rd_q, ONE_I, DEPTH_I);
        end
        start_d = rd_d;
        run_d   = '0;
        state_d = sink_ready_q ? F_DRAIN : F_IDLE;
      end
      F_DRAIN: begin
        if (more_blk) begin
          fill_d = CNT_W'({1'b0, fill_q} - BLK_C);
          run_d  = CNT_W'({1'b0, run_q} + BLK_C);
          rd_d   = idx_add(rd_q, STEP_I, DEPTH_I);
        end else begin
          cmd_push_o = run_q != '0;
          state_d    = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign cmd_o = '{start: start_q, frames: run_q};

  // frames handed to the back and not yet read out of the store
  always_comb begin
    outst_d = outst_q;
    if (cmd_push_o) begin
      outst_d = outst_d + run_q;
    end
    if (status_i.rd_done) begin
      outst_d = outst_d - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      coef_q  <= COEF_RESET;
      px_q    <= '0;
      py_q    <= '0;
      fill_q  <= '0;
      outst_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        coef_q <= cfg_wdata_i;
      end
      px_q    <= px_d;
      py_q    <= py_d;
      fill_q  <= fill_d;
      outst_q <= outst_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      run_q   <= run_d;
    end
  end

  // item payload held during the filter step
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    sink_ready_q <= sink_ready_d;
    prod_q       <= prod_d;
    start_q      <= start_d;
  end

  `DCBB_ASSERT(a_fill_bound, {1'b0, fill_q} <= DEPTH_C, "fill count above store depth")
  `DCBB_ASSERT(a_slot_bound, ({1'b0, fill_q} + {1'b0, outst_q}) <= DEPTH_C, "ring overbooked")
  `DCBB_ASSERT(a_push_room, cmd_push_o |-> !fifo_full_i, "drain command pushed into full queue")
  `DCBB_ASSERT(a_sum_entry, (state_q == F_SUM) |-> $past(accept), "filter step without an item")

endmodule

`default_nettype wire

[rtl/core/dcbb_back.sv]
// ----------------------------------------------------------------------------
// dcbb_back
// sample store and drain engine, one stereo frame per cycle to a ready sink
// ----------------------------------------------------------------------------
`default_nettype none

module dcbb_back
  import dcbb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cmd_valid_i,
  input  drain_cmd_t  cmd_i,
  output logic        cmd_pop_o,
  input  store_wr_t   wr_i,
  output back_status_t status_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output out_item_t   out_data_o
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [IDX_W:0] DEPTH_I = (IDX_W+1)'(STORE_DEPTH);
  localparam logic [IDX_W:0] ONE_I   = (IDX_W+1)'(1);

  logic signed [SMP_W-1:0] mem_q [STORE_DEPTH];
  logic signed [SMP_W-1:0] rdata_q;
  logic                    last_q;
  logic                    active_q, active_d;
  logic [IDX_W-1:0]        addr_q, addr_d;
  logic [CNT_W-1:0]        remain_q, remain_d;
  logic                    out_valid_q, out_valid_d;
  logic                    rd_en;

  // read when the output register is free or being emptied
  assign cmd_pop_o = !active_q && cmd_valid_i;
  assign rd_en     = active_q && (!out_valid_q || out_ready_i);

  // drain sequencing
  always_comb begin
    active_d    = active_q;
    addr_d      = addr_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q;
    if (cmd_pop_o) begin
      active_d = 1'b1;
      addr_d   = cmd_i.start;
      remain_d = cmd_i.frames;
    end
    if (rd_en) begin
      addr_d   = idx_add(addr_q, ONE_I, DEPTH_I);
      remain_d = remain_q - CNT_W'(1);
      if (remain_q == CNT_W'(1)) begin
        active_d = 1'b0;
      end
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      addr_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      addr_q      <= addr_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // store write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  // registered read straight into the output register
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[addr_q[AW-1:0]];
      last_q  <= remain_q == CNT_W'(1);
    end
  end

  assign status_o    = '{rd_done: rd_en, busy: active_q || out_valid_q};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{left: rdata_q, right: rdata_q, last_of_run: last_q};

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - dc blocked sample block buffer testbench
// drives pushes and clears through the input handshake, runs its own copy of
// the dc blocking filter and ring store, and checks every drained frame in
// order; the pole coefficient is changed between phases while the block idles
// ----------------------------------------------------------------------------
module tb_top;
  import dcbb_pkg::*;

  localparam int unsigned BLOCK        = 16;
  localparam int unsigned DEPTH        = 64;
  localparam int          Y_TOP        = 8388607;
  localparam int          Y_BOTTOM     = -8388608;
  localparam int          PCM_TOP      = 32767;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned LIMIT_CYCLES     = 2000000;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_item_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_item_t       out_data_o;
  logic            cfg_we_i    = 1'b0;
  logic [COEF_W-1:0] cfg_wdata_i = '0;

  // items waiting to be offered, frames waiting to be drained
  in_item_t  samples_to_send[$];
  out_item_t frames_due[$];

  // filter and ring state as the block should hold it
  logic [COEF_W-1:0]       pole    = COEF_RESET;
  logic signed [SMP_W-1:0] last_in = '0;
  logic signed [Y_W-1:0]   last_y  = '0;
  logic signed [SMP_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]        rd_ptr  = '0;
  logic [IDX_W-1:0]        wr_ptr  = '0;
  logic [CNT_W-1:0]        fill    = '0;

  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_taken     = 0;
  bit          sender_gaps_on = 1'b1;

  dc_blocked_sample_block_buffer #(
    .BLOCK_FRAMES(BLOCK),
    .STORE_DEPTH (DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // filter one item into the ring and queue the frames it drains
  task automatic filter_and_drain(input in_item_t item);
    logic signed [40:0]      product;
    logic signed [31:0]      sum;
    logic signed [SMP_W-1:0] pcm;
    logic [IDX_W-1:0]        idx;
    out_item_t               frame;
    int                      blocks;
    if (item.op == OP_CLEAR) begin
      rd_ptr  = '0;
      wr_ptr  = '0;
      fill    = '0;
      last_in = '0;
      last_y  = '0;
    end else begin
      // y = x - x_prev + floor(R * y_prev / 2^16), saturated to 24 bits
      product = last_y * $signed({1'b0, pole});
      sum = $signed(item.sample) - last_in + (product >>> 16);
      if (sum > Y_TOP) sum = Y_TOP;
      if (sum < Y_BOTTOM) sum = Y_BOTTOM;
      last_in = item.sample;
      last_y  = sum[Y_W-1:0];
      pcm = sum[SMP_W-1:0];
      if (sum > PCM_TOP) pcm = 16'sd32767;
      if (sum < -PCM_TOP) pcm = -16'sd32767;
      // full ring drops its oldest entry
      ring[wr_ptr] = pcm;
      wr_ptr = wr_ptr + 1'b1;
      if (fill < DEPTH) fill = fill + 1'b1;
      else rd_ptr = rd_ptr + 1'b1;
      // drain every complete block, oldest first
      if (item.sink_ready) begin
        blocks = fill / BLOCK;
        for (int b = 0; b < blocks; b++) begin
          for (int i = 0; i < BLOCK; i++) begin
            idx = rd_ptr + IDX_W'(i);
            frame.left        = ring[idx];
            frame.right       = ring[idx];
            frame.last_of_run = (b == blocks - 1) && (i == BLOCK - 1);
            frames_due.push_back(frame);
          end
          rd_ptr = rd_ptr + IDX_W'(BLOCK);
          fill   = fill - CNT_W'(BLOCK);
        end
      end
    end
  endtask

  // input driver, predicts on every accepted item
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        filter_and_drain(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (samples_to_send.size() > 0) begin
          in_data_i  <= samples_to_send.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= sender_gaps_on ? idle_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // sink ready pattern, with a long hold-off on request
  int unsigned sink_stall;
  int unsigned sink_run;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_stall  <= 0;
      sink_run    <= 0;
    end else if (hold_taken != hold_requests) begin
      hold_taken  <= hold_requests;
      sink_stall  <= SINK_HOLD_CYCLES;
      sink_run    <= 0;
      out_ready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall  <= sink_stall - 1;
      out_ready_i <= 1'b0;
    end else if (sink_run > 0) begin
      sink_run    <= sink_run - 1;
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      sink_stall  <= idle_gap();
      sink_run    <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 24);
    end
  end

  // frame checker
  out_item_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: left %0d right %0d last_of_run %0b",
               out_data_o.left, out_data_o.right, out_data_o.last_of_run);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (out_data_o.left !== want.left) begin
          $error("left: expected %0d, got %0d", want.left, out_data_o.left);
          mismatches++;
        end
        if (out_data_o.right !== want.right) begin
          $error("right: expected %0d, got %0d", want.right, out_data_o.right);
          mismatches++;
        end
        if (out_data_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b",
                 want.last_of_run, out_data_o.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_item(input op_e op, input logic [SMP_W-1:0] s, input logic rdy);
    in_item_t item;
    item.op         = op;
    item.sample     = s;
    item.sink_ready = rdy;
    samples_to_send.push_back(item);
  endtask

  function automatic logic [SMP_W-1:0] pick_sample(input int unsigned style,
                                                    input logic [SMP_W-1:0] level);
    case (style)
      0: return SMP_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return SMP_W'($urandom_range(0, 511)) - 16'd256;
      default: return level + SMP_W'($urandom_range(0, 15)) - 16'd8;
    endcase
  endfunction

  // runs of pushes ending in a drain, plus stray clears and single pushes
  task automatic queue_random_runs(input int unsigned target);
    int unsigned        added;
    int unsigned        run_len;
    int unsigned        kind;
    int unsigned        style;
    logic [SMP_W-1:0]   level;
    added = 0;
    while (added < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // an occasional run long enough to overrun the ring
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 72)
                                              : $urandom_range(1, 40);
        style = $urandom_range(0, 3);
        level = SMP_W'($urandom);
        for (int k = 0; k < run_len; k++) begin
          add_item(OP_PUSH, pick_sample(style, level),
                   (k == run_len - 1) || ($urandom_range(0, 9) == 0));
        end
        added += run_len;
      end else if (kind == 6) begin
        add_item(OP_CLEAR, SMP_W'($urandom), 1'($urandom));
        added++;
      end else begin
        add_item(OP_PUSH, pick_sample($urandom_range(0, 3), SMP_W'($urandom)),
                 1'($urandom));
        added++;
      end
    end
  endtask

  // wait until everything sent has been drained and the block is quiet
  task automatic settle_block();
    do @(negedge clk_i);
    while (samples_to_send.size() != 0 || in_valid_i || frames_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_pole(input logic [COEF_W-1:0] r);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pole = r;
    @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes and clamping at the reset pole, one block drained on the last
    add_item(OP_PUSH, 16'h0000, 1'b0);
    add_item(OP_PUSH, 16'h7FFF, 1'b0);
    add_item(OP_PUSH, 16'h7FFF, 1'b0);
    add_item(OP_PUSH, 16'h8000, 1'b0);
    add_item(OP_PUSH, 16'h8000, 1'b0);
    add_item(OP_PUSH, 16'h7FFF, 1'b0);
    add_item(OP_PUSH, 16'hFFFF, 1'b0);
    add_item(OP_PUSH, 16'h0000, 1'b0);
    add_item(OP_PUSH, 16'h0001, 1'b0);
    add_item(OP_PUSH, 16'h5555, 1'b0);
    add_item(OP_PUSH, 16'hAAAA, 1'b0);
    add_item(OP_PUSH, 16'd100, 1'b0);
    add_item(OP_PUSH, 16'hFF9C, 1'b0);
    add_item(OP_PUSH, 16'h7FFF, 1'b0);
    add_item(OP_PUSH, 16'h8000, 1'b0);
    add_item(OP_PUSH, 16'h0000, 1'b1);
    // clear ignores sink_ready, then a short run gives nothing to drain
    add_item(OP_CLEAR, 16'h8000, 1'b1);
    add_item(OP_PUSH, 16'd1234, 1'b1);
    add_item(OP_PUSH, 16'd5, 1'b0);
    add_item(OP_CLEAR, 16'h7FFF, 1'b0);
    settle_block();

    // random phases over several poles, extremes first
    set_pole(16'hFFFF);
    queue_random_runs(8);
    settle_block();
    set_pole(16'h0000);
    sender_gaps_on = 1'b0;
    queue_random_runs(8);
    settle_block();
    sender_gaps_on = 1'b1;
    set_pole(COEF_W'($urandom_range(1, 65534)));
    queue_random_runs(8);
    settle_block();
    set_pole(16'h8000);
    sender_gaps_on = ($urandom_range(0, 3) != 0);
    queue_random_runs(8);
    settle_block();

    // sink held off while pushes keep coming, so the input stalls
    set_pole(COEF_RESET);
    sender_gaps_on = 1'b0;
    hold_requests++;
    for (int k = 0; k < 70; k++) begin
      add_item(OP_PUSH, pick_sample($urandom_range(0, 3), SMP_W'($urandom)), 1'b1);
    end
    settle_block();

    if (frames_due.size() != 0) begin
      $error("%0d frames never drained", frames_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
